>>> hdl/mts_pkg.sv
// Shared types and constants for the min tracking stack.
package mts_pkg;

    localparam int DEPTH   = 128;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESULT
    } state_t;

endpackage

>>> hdl/mts_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module mts_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/min_tracking_stack.sv
// Top level of the bounded stack that reports its running minimum.
//
//   channel   direction  ports
//   s_        in         s_valid, s_ready, s_func, s_value
//   m_        out        m_valid, m_ready, m_status, m_popped_value, m_top_value,
//                        m_minimum, m_not_empty, m_depth
//
// A push, or any operation that fails, goes from S_IDLE straight to S_RESULT; a successful pop
// passes through S_READ first, as the new top entries come from registered memory reads.
// The top entries of both stacks are cached in registers, so a push needs no read.
// Reset is synchronous and active low; it empties both stacks at once.
// A new transaction is taken while an earlier result still waits in the output register;
// the block stalls only when a finished result cannot yet move into that register.
module min_tracking_stack (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic signed [mts_pkg::DATA_W-1:0]  s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic signed [mts_pkg::DATA_W-1:0]  m_popped_value,
    output logic signed [mts_pkg::DATA_W-1:0]  m_top_value,
    output logic signed [mts_pkg::DATA_W-1:0]  m_minimum,
    output logic                               m_not_empty,
    output logic [mts_pkg::DEPTH_W-1:0]        m_depth
);

    localparam int CW = mts_pkg::CNT_W;
    localparam int AW = mts_pkg::ADDR_W;
    localparam int DW = mts_pkg::DATA_W;

    mts_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    main_count_reg, main_count_next;
    logic [CW-1:0]    min_count_reg, min_count_next;
    logic signed [DW-1:0] main_top_reg, main_top_next;
    logic signed [DW-1:0] min_top_reg, min_top_next;
    mts_pkg::status_t status_reg, status_next;
    logic [DW-1:0]    popped_reg, popped_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [DW-1:0]    m_popped_reg, m_popped_next;
    logic [DW-1:0]    m_top_reg, m_top_next;
    logic [DW-1:0]    m_min_reg, m_min_next;
    logic             m_not_empty_reg, m_not_empty_next;
    logic [mts_pkg::DEPTH_W-1:0] m_depth_reg, m_depth_next;

    logic             s_accept;
    logic             out_free;
    logic             is_pop;
    logic             main_we, min_we;
    logic [AW-1:0]    main_waddr, min_waddr, main_raddr, min_raddr;
    logic [DW-1:0]    main_rdata, min_rdata;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_pop   = (s_func == mts_pkg::FUNC_POP);

    mts_ram #(.DATA_W(DW), .ADDR_W(AW)) u_main_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (s_value),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    mts_ram #(.DATA_W(DW), .ADDR_W(AW)) u_min_ram (
        .aclk  (aclk),
        .we    (min_we),
        .waddr (min_waddr),
        .wdata (s_value),
        .raddr (min_raddr),
        .rdata (min_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mts_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (is_pop && main_count_reg != '0) begin
                        state_next = mts_pkg::S_READ;
                    end else begin
                        state_next = mts_pkg::S_RESULT;
                    end
                end
            end
            mts_pkg::S_READ: begin
                state_next = mts_pkg::S_RESULT;
            end
            mts_pkg::S_RESULT: begin
                if (out_free) begin
                    state_next = mts_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == mts_pkg::S_IDLE);
        main_count_next  = main_count_reg;
        min_count_next   = min_count_reg;
        main_top_next    = main_top_reg;
        min_top_next     = min_top_reg;
        status_next      = status_reg;
        popped_next      = popped_reg;
        main_we          = 1'b0;
        min_we           = 1'b0;
        main_waddr       = main_count_reg[AW-1:0];
        min_waddr        = min_count_reg[AW-1:0];
        main_raddr       = AW'(main_count_reg - CW'(2));
        min_raddr        = AW'(min_count_reg - CW'(1));
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_popped_next    = m_popped_reg;
        m_top_next       = m_top_reg;
        m_min_next       = m_min_reg;
        m_not_empty_next = m_not_empty_reg;
        m_depth_next     = m_depth_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mts_pkg::S_IDLE: begin
                if (s_accept) begin
                    status_next = mts_pkg::ST_OK;
                    popped_next = '0;
                    if (!is_pop) begin
                        if (main_count_reg >= CW'(mts_pkg::DEPTH)) begin
                            status_next = mts_pkg::ST_OVERFLOW;
                        end else begin
                            main_we         = 1'b1;
                            main_count_next = main_count_reg + CW'(1);
                            main_top_next   = s_value;
                            if (min_count_reg == '0 || s_value <= min_top_reg) begin
                                min_we         = 1'b1;
                                min_count_next = min_count_reg + CW'(1);
                                min_top_next   = s_value;
                            end
                        end
                    end else begin
                        if (main_count_reg == '0) begin
                            status_next = mts_pkg::ST_UNDERFLOW;
                        end else begin
                            popped_next     = main_top_reg;
                            main_count_next = main_count_reg - CW'(1);
                            if (min_count_reg != '0 && main_top_reg == min_top_reg) begin
                                min_count_next = min_count_reg - CW'(1);
                            end
                            min_raddr = AW'(min_count_next - CW'(1));
                        end
                    end
                end
            end
            mts_pkg::S_READ: begin
                main_top_next = main_rdata;
                min_top_next  = min_rdata;
            end
            mts_pkg::S_RESULT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = status_reg;
                    m_popped_next    = popped_reg;
                    m_not_empty_next = (main_count_reg != '0);
                    m_depth_next     = mts_pkg::DEPTH_W'(main_count_reg);
                    m_top_next       = (main_count_reg != '0) ? main_top_reg : '0;
                    m_min_next       = (main_count_reg != '0 && min_count_reg != '0) ?
                                       min_top_reg : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mts_pkg::S_IDLE;
            main_count_reg <= '0;
            min_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            main_count_reg <= main_count_next;
            min_count_reg  <= min_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_top_reg    <= main_top_next;
        min_top_reg     <= min_top_next;
        status_reg      <= status_next;
        popped_reg      <= popped_next;
        m_status_reg    <= m_status_next;
        m_popped_reg    <= m_popped_next;
        m_top_reg       <= m_top_next;
        m_min_reg       <= m_min_next;
        m_not_empty_reg <= m_not_empty_next;
        m_depth_reg     <= m_depth_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_popped_value = m_popped_reg;
    assign m_top_value    = m_top_reg;
    assign m_minimum      = m_min_reg;
    assign m_not_empty    = m_not_empty_reg;
    assign m_depth        = m_depth_reg;

    a_min_below_main: assert property (@(posedge aclk) disable iff (!aresetn)
        min_count_reg <= main_count_reg)
        else $error("min stack holds more entries than the main stack");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        main_count_reg <= CW'(mts_pkg::DEPTH))
        else $error("main stack count beyond capacity");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !is_pop && main_count_reg < CW'(mts_pkg::DEPTH)
        |=> main_count_reg == $past(main_count_reg) + CW'(1))
        else $error("accepted push did not grow the stack");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_pop && main_count_reg != '0
        |=> main_count_reg == $past(main_count_reg) - CW'(1))
        else $error("accepted pop did not shrink the stack");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_not_empty_reg == (m_depth_reg != '0)))
        else $error("not_empty disagrees with depth");

endmodule
